FILE: sv/tce_pkg.sv
// shared types and constants for the two-register execute step
// opcode codes, memory and program sizes, and the decoded request passed front to back
// no dependencies
`default_nettype none

package tce_pkg;

   localparam int DATA_WORDS    = 256;
   localparam int PROGRAM_DEPTH = 256;
   localparam int ADDR_W        = $clog2(DATA_WORDS);
   localparam int PC_W          = $clog2(PROGRAM_DEPTH);
   localparam int WORD_W        = 32;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      OP_MOV   = 4'd0,
      OP_ADD   = 4'd1,
      OP_SUB   = 4'd2,
      OP_CMP   = 4'd3,
      OP_JZ    = 4'd4,
      OP_JN    = 4'd5,
      OP_JMP   = 4'd6,
      OP_LOAD  = 4'd7,
      OP_STORE = 4'd8
   } opcode_type;

   typedef struct packed {
      opcode_type          op;
      logic                illegal;
      logic                reg_sel;
      logic [WORD_W-1:0]   operand;
      logic                addr_ok;
      logic                target_ok;
   } instr_type;

endpackage

`default_nettype wire

FILE: sv/two_register_cpu_execute_step.sv
// Execute step of a two-register machine (A, B, zero/negative flags, program
// counter, 256-word data memory). Each request is one instruction; each
// request yields exactly one response with the new program counter, both
// registers, both flags and a fault bit.
// Channels: req_* in, rsp_* out, valid/stall on each; a transfer happens on
// a rising edge with valid high and stall low.
// Path: queue, then issue register (memory read), then execute into the
// result register. Throughput: one instruction per cycle while rsp_stall
// is low; the data memory read sits one stage ahead of execute and a store
// directly before a load is forwarded.
// A stalled response holds in the output register; the two-entry queue keeps
// taking requests until it fills, then req_stall rises.
// Reset (synchronous, active high) clears the registers, flags, program
// counter and all data words, the latter through per-word valid bits, so the
// block is usable as soon as reset is released.
// uses tce_pkg, tce_front, tce_back
`default_nettype none

module two_register_cpu_execute_step (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [3:0]          req_func,
   input  wire logic                req_reg_sel,
   input  wire logic signed [31:0]  req_operand,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_next_pc,
   output logic signed [31:0]       rsp_reg_a_value,
   output logic signed [31:0]       rsp_reg_b_value,
   output logic                     rsp_zero_out,
   output logic                     rsp_negative_out,
   output logic                     rsp_fault
);

   logic                 head_valid;
   logic                 pop;
   tce_pkg::instr_type   head;

   tce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_reg_sel (req_reg_sel),
      .req_operand (req_operand),
      .pop         (pop),
      .head_valid  (head_valid),
      .head        (head)
   );

   tce_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_reg_a_value  (rsp_reg_a_value),
      .rsp_reg_b_value  (rsp_reg_b_value),
      .rsp_zero_out     (rsp_zero_out),
      .rsp_negative_out (rsp_negative_out),
      .rsp_fault        (rsp_fault)
   );

endmodule

`default_nettype wire

FILE: sv/tce_front.sv
// front end: takes requests, decodes and range-checks them, and queues them
// for the execute back end; uses tce_pkg
`default_nettype none

module tce_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [3:0]                  req_func,
   input  wire logic                        req_reg_sel,
   input  wire logic signed [31:0]          req_operand,
   input  wire logic                        pop,
   output logic                             head_valid,
   output tce_pkg::instr_type               head
);

   tce_pkg::instr_type                 entry_ff [tce_pkg::QUEUE_DEPTH];
   tce_pkg::instr_type                 dec;
   logic [tce_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [tce_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [tce_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                               push;

   // classify the request
   always_comb begin
      dec.op        = tce_pkg::opcode_type'(req_func);
      dec.illegal   = (req_func > 4'(tce_pkg::OP_STORE));
      dec.reg_sel   = req_reg_sel;
      dec.operand   = req_operand;
      dec.addr_ok   = !req_operand[31] &&
                      (req_operand < 32'(tce_pkg::DATA_WORDS));
      dec.target_ok = !req_operand[31] &&
                      (req_operand < 32'(tce_pkg::PROGRAM_DEPTH));
   end

   assign req_stall  = (count_ff == tce_pkg::QCNT_W'(tce_pkg::QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tce_pkg::QPTR_W'(tce_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tce_pkg::QPTR_W'(tce_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

FILE: sv/tce_back.sv
// back end: reads data memory, executes the queued instruction against the
// architectural state and holds the result register; uses tce_pkg
`default_nettype none

module tce_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire tce_pkg::instr_type    head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_next_pc,
   output logic signed [31:0]         rsp_reg_a_value,
   output logic signed [31:0]         rsp_reg_b_value,
   output logic                       rsp_zero_out,
   output logic                       rsp_negative_out,
   output logic                       rsp_fault
);

   localparam int W = tce_pkg::WORD_W;

   // data memory with per-word valid bits so reset reads as zero
   logic [W-1:0]                  mem [tce_pkg::DATA_WORDS];
   logic [tce_pkg::DATA_WORDS-1:0] mem_vld_ff;

   // architectural state
   logic [tce_pkg::PC_W-1:0]  pc_ff, pc_in;
   logic [W-1:0]              a_ff, a_in;
   logic [W-1:0]              b_ff, b_in;
   logic                      zf_ff, zf_in;
   logic                      nf_ff, nf_in;

   // issue stage
   logic                      x1_valid_ff;
   tce_pkg::instr_type        x1_ff;
   logic [W-1:0]              rd_data_ff;
   logic                      rd_vld_ff;
   logic                      byp_hit_ff, byp_hit_in;
   logic [W-1:0]              byp_data_ff;

   // result register
   logic                      out_valid_ff;
   logic [7:0]                out_pc_ff;
   logic [W-1:0]              out_a_ff;
   logic [W-1:0]              out_b_ff;
   logic                      out_zf_ff;
   logic                      out_nf_ff;
   logic                      out_fault_ff;

   logic                      out_free;
   logic                      ex_fire;
   logic                      ex_fault;
   logic                      st_we;
   logic                      take;
   logic [W-1:0]              reg_cur;
   logic [W-1:0]              sum;
   logic [W-1:0]              diff;
   logic [W-1:0]              load_val;
   logic [tce_pkg::PC_W-1:0]  seq_pc;
   logic [tce_pkg::ADDR_W-1:0] x1_idx;
   logic [tce_pkg::ADDR_W-1:0] head_idx;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign ex_fire  = x1_valid_ff && out_free;
   assign pop      = head_valid && (!x1_valid_ff || ex_fire);
   assign x1_idx   = x1_ff.operand[tce_pkg::ADDR_W-1:0];
   assign head_idx = head.operand[tce_pkg::ADDR_W-1:0];
   assign st_we    = ex_fire && !x1_ff.illegal && (x1_ff.op == tce_pkg::OP_STORE) &&
                     x1_ff.addr_ok;
   // a store leaving now is missed by the read of the load entering now
   assign byp_hit_in = st_we && (x1_idx == head_idx);

   assign reg_cur  = x1_ff.reg_sel ? b_ff : a_ff;
   assign sum      = reg_cur + x1_ff.operand;
   assign diff     = reg_cur - x1_ff.operand;
   assign seq_pc   = (pc_ff == tce_pkg::PC_W'(tce_pkg::PROGRAM_DEPTH - 1)) ?
                     '0 : pc_ff + 1'b1;
   assign load_val = byp_hit_ff ? byp_data_ff : (rd_vld_ff ? rd_data_ff : '0);

   always_comb begin
      pc_in    = pc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      zf_in    = zf_ff;
      nf_in    = nf_ff;
      ex_fault = 1'b0;
      take     = 1'b0;
      if (x1_ff.illegal) begin
         ex_fault = 1'b1;
      end else begin
         case (x1_ff.op)
            tce_pkg::OP_MOV, tce_pkg::OP_ADD, tce_pkg::OP_SUB: begin
               if (x1_ff.op == tce_pkg::OP_MOV) begin
                  if (x1_ff.reg_sel) b_in = x1_ff.operand; else a_in = x1_ff.operand;
               end else if (x1_ff.op == tce_pkg::OP_ADD) begin
                  if (x1_ff.reg_sel) b_in = sum; else a_in = sum;
               end else begin
                  if (x1_ff.reg_sel) b_in = diff; else a_in = diff;
               end
               zf_in = (a_in == '0) || (b_in == '0);
               nf_in = a_in[W-1] || b_in[W-1];
               pc_in = seq_pc;
            end
            tce_pkg::OP_CMP: begin
               zf_in = (diff == '0);
               nf_in = diff[W-1];
               pc_in = seq_pc;
            end
            tce_pkg::OP_JZ, tce_pkg::OP_JN, tce_pkg::OP_JMP: begin
               if (x1_ff.op == tce_pkg::OP_JMP) begin
                  take = 1'b1;
               end else if (x1_ff.op == tce_pkg::OP_JZ) begin
                  take = zf_ff;
               end else begin
                  take = nf_ff;
               end
               if (!take) begin
                  pc_in = seq_pc;
               end else if (x1_ff.target_ok) begin
                  pc_in = x1_ff.operand[tce_pkg::PC_W-1:0];
               end else begin
                  ex_fault = 1'b1;
               end
            end
            tce_pkg::OP_LOAD: begin
               if (x1_ff.addr_ok) begin
                  if (x1_ff.reg_sel) b_in = load_val; else a_in = load_val;
                  zf_in = (load_val == '0);
                  nf_in = load_val[W-1];
                  pc_in = seq_pc;
               end else begin
                  ex_fault = 1'b1;
               end
            end
            tce_pkg::OP_STORE: begin
               if (x1_ff.addr_ok) begin
                  pc_in = seq_pc;
               end else begin
                  ex_fault = 1'b1;
               end
            end
            default: begin
               ex_fault = 1'b1;
            end
         endcase
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         a_ff         <= '0;
         b_ff         <= '0;
         zf_ff        <= 1'b0;
         nf_ff        <= 1'b0;
         mem_vld_ff   <= '0;
         x1_valid_ff  <= 1'b0;
         byp_hit_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ex_fire) begin
            pc_ff <= pc_in;
            a_ff  <= a_in;
            b_ff  <= b_in;
            zf_ff <= zf_in;
            nf_ff <= nf_in;
         end
         if (st_we) begin
            mem_vld_ff[x1_idx] <= 1'b1;
         end
         if (pop) begin
            x1_valid_ff <= 1'b1;
            byp_hit_ff  <= byp_hit_in;
         end else if (ex_fire) begin
            x1_valid_ff <= 1'b0;
            byp_hit_ff  <= 1'b0;
         end
         if (ex_fire) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         x1_ff       <= head;
         rd_data_ff  <= mem[head_idx];
         rd_vld_ff   <= mem_vld_ff[head_idx];
         byp_data_ff <= reg_cur;
      end
      if (ex_fire) begin
         out_pc_ff    <= 8'(pc_in);
         out_a_ff     <= a_in;
         out_b_ff     <= b_in;
         out_zf_ff    <= zf_in;
         out_nf_ff    <= nf_in;
         out_fault_ff <= ex_fault;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         mem[x1_idx] <= reg_cur;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_next_pc      = out_pc_ff;
   assign rsp_reg_a_value  = out_a_ff;
   assign rsp_reg_b_value  = out_b_ff;
   assign rsp_zero_out     = out_zf_ff;
   assign rsp_negative_out = out_nf_ff;
   assign rsp_fault        = out_fault_ff;

`ifndef SYNTH
   // a rejected instruction leaves the machine state alone
   a_fault_keeps_state: assert property (@(posedge clock) disable iff (reset)
      ex_fire && ex_fault |=> (pc_ff == $past(pc_ff)) && (a_ff == $past(a_ff)) &&
                              (b_ff == $past(b_ff)))
      else $error("faulting instruction changed state");

   // forwarding only ever applies to an instruction sitting in issue
   a_bypass_needs_issue: assert property (@(posedge clock) disable iff (reset)
      byp_hit_ff |-> x1_valid_ff)
      else $error("store forwarding flagged with empty issue stage");

   // every executed instruction shows up in the result register
   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      ex_fire |=> out_valid_ff && (out_fault_ff == $past(ex_fault)))
      else $error("executed instruction produced no result");
`endif

endmodule

`default_nettype wire

FILE: tb/tce_execute_checker.sv
// watches both channels of the two-register execute step, keeps its own copy of the
// machine state and compares every response with the one worked out for its request
// depends on tce_pkg for the opcodes and the memory and program sizes
module tce_execute_checker
   import tce_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic [3:0]          req_func,
   input  wire logic                req_reg_sel,
   input  wire logic signed [31:0]  req_operand,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic [7:0]          rsp_next_pc,
   input  wire logic signed [31:0]  rsp_reg_a_value,
   input  wire logic signed [31:0]  rsp_reg_b_value,
   input  wire logic                rsp_zero_out,
   input  wire logic                rsp_negative_out,
   input  wire logic                rsp_fault,
   output int                       mismatch_count,
   output int                       pending
);

   typedef struct packed {
      logic [7:0]          next_pc;
      logic [WORD_W-1:0]   reg_a;
      logic [WORD_W-1:0]   reg_b;
      logic                zero;
      logic                negative;
      logic                fault;
   } step_result_type;

   logic [PC_W-1:0]     pc;
   logic [WORD_W-1:0]   reg_a;
   logic [WORD_W-1:0]   reg_b;
   logic                zf;
   logic                nf;
   logic [WORD_W-1:0]   data_mem [DATA_WORDS];
   step_result_type     expected_q [$];
   int                  errors = 0;

   // negative patterns never pass
   function automatic logic below_limit(input logic [31:0] v, input int limit);
      return !v[31] && (v < 32'(limit));
   endfunction

   function automatic step_result_type execute_instr(input logic [3:0] func, input logic sel,
                                                     input logic [31:0] operand);
      logic [WORD_W-1:0]   cur;
      logic [WORD_W-1:0]   diff;
      logic [PC_W-1:0]     seq;
      logic                bad;
      logic                take;
      step_result_type     r;
      cur = sel ? reg_b : reg_a;
      seq = pc + 1'b1;
      bad = 1'b0;
      case (func)
         OP_MOV, OP_ADD, OP_SUB: begin
            if (func == OP_MOV)
               cur = operand;
            else if (func == OP_ADD)
               cur = cur + operand;
            else
               cur = cur - operand;
            if (sel)
               reg_b = cur;
            else
               reg_a = cur;
            zf = (reg_a == '0) || (reg_b == '0);
            nf = reg_a[WORD_W-1] | reg_b[WORD_W-1];
            pc = seq;
         end
         OP_CMP: begin
            diff = cur - operand;
            zf = (diff == '0);
            nf = diff[WORD_W-1];
            pc = seq;
         end
         OP_JZ, OP_JN, OP_JMP: begin
            take = (func == OP_JMP) || ((func == OP_JZ) ? zf : nf);
            if (!take)
               pc = seq;
            else if (below_limit(operand, PROGRAM_DEPTH))
               pc = operand[PC_W-1:0];
            else
               bad = 1'b1;
         end
         OP_LOAD: begin
            if (below_limit(operand, DATA_WORDS)) begin
               cur = data_mem[operand[ADDR_W-1:0]];
               if (sel)
                  reg_b = cur;
               else
                  reg_a = cur;
               zf = (cur == '0);
               nf = cur[WORD_W-1];
               pc = seq;
            end else begin
               bad = 1'b1;
            end
         end
         OP_STORE: begin
            if (below_limit(operand, DATA_WORDS)) begin
               data_mem[operand[ADDR_W-1:0]] = cur;
               pc = seq;
            end else begin
               bad = 1'b1;
            end
         end
         default: begin
            bad = 1'b1;
         end
      endcase
      r.next_pc  = 8'(pc);
      r.reg_a    = reg_a;
      r.reg_b    = reg_b;
      r.zero     = zf;
      r.negative = nf;
      r.fault    = bad;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      step_result_type want;
      if (reset) begin
         pc = '0;
         reg_a = '0;
         reg_b = '0;
         zf = 1'b0;
         nf = 1'b0;
         foreach (data_mem[i])
            data_mem[i] = '0;
         expected_q.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_q.push_back(execute_instr(req_func, req_reg_sel, req_operand));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response with no request outstanding, pc %h", $time,
                        rsp_next_pc);
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("next_pc", 32'(want.next_pc), 32'(rsp_next_pc));
               check_field("reg_a_value", want.reg_a, rsp_reg_a_value);
               check_field("reg_b_value", want.reg_b, rsp_reg_b_value);
               check_field("zero_out", 32'(want.zero), 32'(rsp_zero_out));
               check_field("negative_out", 32'(want.negative), 32'(rsp_negative_out));
               check_field("fault", 32'(want.fault), 32'(rsp_fault));
            end
         end
      end
      // published after the edge so the top never races the update
      pending <= expected_q.size();
      mismatch_count <= errors;
   end

endmodule

FILE: tb/two_register_cpu_execute_step_test.sv
// top of the execute step testbench: clock, reset, request and response drivers and verdict
// runs a directed instruction list then random programs; tce_execute_checker does the comparing
// depends on tce_pkg, tce_execute_checker and two_register_cpu_execute_step
module two_register_cpu_execute_step_test;
   import tce_pkg::*;

   localparam logic [3:0] FUNC_INVALID_LO = 4'd9;
   localparam logic [3:0] FUNC_INVALID_HI = 4'd15;
   localparam int         RANDOM_ITEMS    = 850;
   localparam int         CYCLE_LIMIT     = 200000;
   localparam int         HOLD_OFF_CYCLES = 60;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [3:0]          req_func = '0;
   logic                req_reg_sel = 1'b0;
   logic signed [31:0]  req_operand = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [7:0]          rsp_next_pc;
   logic signed [31:0]  rsp_reg_a_value;
   logic signed [31:0]  rsp_reg_b_value;
   logic                rsp_zero_out;
   logic                rsp_negative_out;
   logic                rsp_fault;
   int                  mismatch_count;
   int                  pending;
   int                  cycle_count = 0;
   int                  hold_cycles = 0;
   logic                no_idle = 1'b0;

   two_register_cpu_execute_step u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_reg_sel      (req_reg_sel),
      .req_operand      (req_operand),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_reg_a_value  (rsp_reg_a_value),
      .rsp_reg_b_value  (rsp_reg_b_value),
      .rsp_zero_out     (rsp_zero_out),
      .rsp_negative_out (rsp_negative_out),
      .rsp_fault        (rsp_fault)
   );

   tce_execute_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_reg_sel      (req_reg_sel),
      .req_operand      (req_operand),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_reg_a_value  (rsp_reg_a_value),
      .rsp_reg_b_value  (rsp_reg_b_value),
      .rsp_zero_out     (rsp_zero_out),
      .rsp_negative_out (rsp_negative_out),
      .rsp_fault        (rsp_fault),
      .mismatch_count   (mismatch_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("two_register_cpu_execute_step_test failed");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off counted down here
   always begin
      @(posedge clock);
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 6);
      end
   end

   task automatic send_instr(input logic [3:0] func, input logic sel,
                             input logic [31:0] operand);
      req_valid   <= 1'b1;
      req_func    <= func;
      req_reg_sel <= sel;
      req_operand <= operand;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (!no_idle && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_operand(input logic [3:0] func);
      case (func)
         OP_LOAD, OP_STORE: begin
            // a narrow window in nearly half of the picks so loads find earlier stores
            if ($urandom_range(9) == 0)
               return $urandom;
            else if ($urandom_range(1) == 0)
               return $urandom_range(15);
            else
               return $urandom_range(DATA_WORDS - 1);
         end
         OP_JZ, OP_JN, OP_JMP: begin
            if ($urandom_range(9) == 0)
               return $urandom;
            return $urandom_range(PROGRAM_DEPTH - 1);
         end
         default: begin
            case ($urandom_range(5))
               0:       return 32'h7fff_ffff;
               1:       return 32'h8000_0000;
               2:       return $urandom_range(3);
               3:       return -$urandom_range(3);
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   initial begin
      logic [3:0] func;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero flag set, then a taken jump out of range and one in range
      send_instr(OP_MOV, 1'b0, 32'h0);
      send_instr(OP_JZ, 1'b0, 32'h7fff_ffff);
      send_instr(OP_JZ, 1'b0, 32'd5);
      // wrap on add and subtract
      send_instr(OP_MOV, 1'b0, 32'h7fff_ffff);
      send_instr(OP_MOV, 1'b1, 32'h8000_0000);
      send_instr(OP_ADD, 1'b0, 32'd1);
      send_instr(OP_SUB, 1'b1, 32'd1);
      send_instr(OP_CMP, 1'b1, 32'h7fff_ffff);
      // memory at both ends, then addresses out of range
      send_instr(OP_STORE, 1'b0, 32'd0);
      send_instr(OP_STORE, 1'b1, 32'd255);
      send_instr(OP_LOAD, 1'b0, 32'd255);
      send_instr(OP_LOAD, 1'b1, 32'd0);
      send_instr(OP_LOAD, 1'b0, 32'd256);
      send_instr(OP_LOAD, 1'b1, 32'hffff_ffff);
      send_instr(OP_STORE, 1'b0, 32'd256);
      send_instr(OP_STORE, 1'b1, 32'h8000_0000);
      // jumps on the negative flag and unconditional, then sequential wrap from the last pc
      send_instr(OP_JN, 1'b0, 32'd200);
      send_instr(OP_JN, 1'b0, 32'hffff_ffff);
      send_instr(OP_JMP, 1'b1, 32'd256);
      send_instr(OP_JMP, 1'b1, 32'd255);
      send_instr(OP_MOV, 1'b0, 32'h0);
      send_instr(OP_MOV, 1'b0, 32'd5);
      send_instr(OP_JZ, 1'b1, 32'd3);
      send_instr(FUNC_INVALID_LO, 1'b0, 32'h1234_5678);
      send_instr(FUNC_INVALID_HI, 1'b1, 32'hedcb_a987);
      send_instr(OP_LOAD, 1'b1, 32'd100);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300)
            hold_cycles = HOLD_OFF_CYCLES;
         no_idle = (n >= 500 && n < 650);
         if ($urandom_range(99) < 5)
            func = 4'($urandom_range(FUNC_INVALID_HI, FUNC_INVALID_LO));
         else
            func = 4'($urandom_range(OP_STORE, OP_MOV));
         send_instr(func, 1'($urandom_range(1)), pick_operand(func));
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("two_register_cpu_execute_step_test passed");
      else
         $display("two_register_cpu_execute_step_test failed");
      $finish;
   end

endmodule

FILE: sim.f
sv/tce_pkg.sv
sv/tce_front.sv
sv/tce_back.sv
sv/two_register_cpu_execute_step.sv
tb/tce_execute_checker.sv
tb/two_register_cpu_execute_step_test.sv
